// ===== rtl/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsfd_parser and websocket_frame_deframer.
package wsfd_pkg;

	// Width of the payload length cap register.
	localparam int CAP_W = 21;
	// Width of the declared length as it arrives on the wire.
	localparam int LEN_W = 64;

	// Reset value of the payload length cap.
	localparam logic [CAP_W-1:0] CAP_RESET = 21'd1048576;

	// Parser phase codes.
	localparam int PH_W = 3;
	localparam logic [PH_W-1:0] PH_HDR0    = 3'd0;
	localparam logic [PH_W-1:0] PH_HDR1    = 3'd1;
	localparam logic [PH_W-1:0] PH_EXTLEN  = 3'd2;
	localparam logic [PH_W-1:0] PH_KEY     = 3'd3;
	localparam logic [PH_W-1:0] PH_PAYLOAD = 3'd4;
	localparam logic [PH_W-1:0] PH_HALT    = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [1:0] KIND_EMPTY    = 2'd1;
	localparam logic [1:0] KIND_OVERSIZE = 2'd2;

	// Header constants.
	localparam logic [3:0] OPC_CLOSE  = 4'h8;
	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// One result word from the parser.
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [3:0] opcode;
		logic [7:0] data;
		logic       last;
	} wsfd_result_t;

endpackage

// ===== rtl/wsfd_parser.sv =====
// Frame header parser and payload unmasker, one byte per step.
// Depends on wsfd_pkg for phase codes, result kinds and the result type.
module wsfd_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [7:0]                  rx_byte,
	input  logic [wsfd_pkg::CAP_W-1:0]  cap,
	output wsfd_pkg::wsfd_result_t      res
);
	import wsfd_pkg::*;

	logic [PH_W-1:0]  phase_q, phase_d;
	logic [3:0]       opc_q, opc_d;
	logic             mask_q, mask_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [3:0]       left_q, left_d;
	logic [31:0]      key_q, key_d;
	logic [1:0]       idx_q, idx_d;
	logic             do_len;
	logic             do_body;
	logic             over;
	logic [7:0]       key_byte;
	logic [CAP_W-1:0] cnt_dec;
	wsfd_result_t     res_d;

	// Key byte for the current payload position; first key byte comes first.
	always_comb begin
		case (idx_q)
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// Payload bytes left shrinks by one; after the cap check it fits the cap width.
	assign cnt_dec = len_q[CAP_W-1:0] - {{(CAP_W-1){1'b0}}, 1'b1};

	// Next-state logic for one received byte.
	always_comb begin
		phase_d = phase_q;
		opc_d   = opc_q;
		mask_d  = mask_q;
		len_d   = len_q;
		left_d  = left_q;
		key_d   = key_q;
		idx_d   = idx_q;
		do_len  = 1'b0;
		do_body = 1'b0;
		over    = 1'b0;
		res_d   = '0;

		case (phase_q)
			PH_HDR0: begin
				opc_d   = rx_byte[3:0];
				phase_d = PH_HDR1;
			end
			PH_HDR1: begin
				mask_d = rx_byte[7];
				len_d  = '0;
				if (rx_byte[6:0] == LEN_CODE16) begin
					left_d  = EXT16_BYTES;
					phase_d = PH_EXTLEN;
				end else if (rx_byte[6:0] == LEN_CODE64) begin
					left_d  = EXT64_BYTES;
					phase_d = PH_EXTLEN;
				end else begin
					len_d  = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
					do_len = 1'b1;
				end
			end
			PH_EXTLEN: begin
				len_d  = {len_q[LEN_W-9:0], rx_byte};
				left_d = left_q - 4'd1;
				do_len = (left_d == 4'd0);
			end
			PH_KEY: begin
				key_d   = {key_q[23:0], rx_byte};
				left_d  = left_q - 4'd1;
				do_body = (left_d == 4'd0);
			end
			PH_PAYLOAD: begin
				idx_d = idx_q + 2'd1;
				len_d = {{(LEN_W-CAP_W){1'b0}}, cnt_dec};
				res_d.valid  = 1'b1;
				res_d.kind   = KIND_PAYLOAD;
				res_d.opcode = opc_q;
				res_d.data   = mask_q ? (rx_byte ^ key_byte) : rx_byte;
				res_d.last   = (cnt_dec == '0);
				if (cnt_dec == '0) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				phase_d = PH_HALT;
			end
		endcase

		// Declared length is complete: check against the cap, then the key.
		if (do_len) begin
			over = (|len_d[LEN_W-1:CAP_W]) || (len_d[CAP_W-1:0] > cap);
			if (over) begin
				res_d.valid  = 1'b1;
				res_d.kind   = KIND_OVERSIZE;
				res_d.opcode = OPC_CLOSE;
				res_d.data   = 8'd0;
				res_d.last   = 1'b1;
				phase_d      = PH_HALT;
			end else if (mask_d) begin
				left_d  = KEY_BYTES;
				key_d   = '0;
				phase_d = PH_KEY;
			end else begin
				do_body = 1'b1;
			end
		end

		// Header fully read: an empty frame ends here, otherwise payload follows.
		if (do_body) begin
			if (len_d == '0) begin
				res_d.valid  = 1'b1;
				res_d.kind   = KIND_EMPTY;
				res_d.opcode = opc_d;
				res_d.data   = 8'd0;
				res_d.last   = 1'b1;
				phase_d      = PH_HDR0;
			end else begin
				idx_d   = 2'd0;
				phase_d = PH_PAYLOAD;
			end
		end
	end

	// Parser state advances only on a processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			opc_q   <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			left_q  <= '0;
			key_q   <= '0;
			idx_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			opc_q   <= opc_d;
			mask_q  <= mask_d;
			len_q   <= len_d;
			left_q  <= left_d;
			key_q   <= key_d;
			idx_q   <= idx_d;
		end
	end

	// Result is only meaningful on a processed byte.
	always_comb begin
		res       = res_d;
		res.valid = res_d.valid & step;
	end

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket client-to-server frame deframer with payload unmasking.
// Depends on wsfd_pkg and wsfd_parser.
//
// Usage:
//   Input channel: one received stream byte per word on rx_byte, with
//   in_valid and in_stall. Output channel: one result word per frame payload
//   byte, per empty frame, or one oversize close, with out_valid and out_stall.
//   The cap on the declared payload length is written through cfg_wr_en and
//   cfg_wr_data while the block is idle; it resets to 1048576.
// Timing:
//   A byte accepted at one edge is held in the input register and parsed
//   combinationally; its result, if any, is registered in the output
//   register at the next edge. One byte is taken every cycle while no
//   output word is held by out_stall.
// Reset:
//   Reset returns the parser to the first header byte, clears both registers
//   and restores the cap. After an oversize close every byte is accepted and
//   dropped until reset.
// Stall:
//   While the output word is held by out_stall, the parser pauses and the
//   input register holds its byte; in_stall rises only when that register is
//   full and cannot move on.
module websocket_frame_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 rx_byte,
	input  logic                       cfg_wr_en,
	input  logic [wsfd_pkg::CAP_W-1:0] cfg_wr_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 result_kind,
	output logic [3:0]                 frame_opcode,
	output logic [7:0]                 payload_byte,
	output logic                       last_of_frame
);
	import wsfd_pkg::*;

	logic             vld_s1;
	logic [7:0]       byte_s1;
	logic [CAP_W-1:0] cap_q;
	logic             out_free;
	logic             step;
	wsfd_result_t     res;
	wsfd_result_t     res_q;

	// The output register can take a new word when empty or being drained.
	assign out_free = !res_q.valid || !out_stall;
	assign step     = vld_s1 && out_free;
	assign in_stall = vld_s1 && !out_free;

	// Payload length cap register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// Input register for received bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	wsfd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.cap     (cap_q),
		.res     (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (out_free) begin
			res_q <= res;
		end
	end

	assign out_valid     = res_q.valid;
	assign result_kind   = res_q.kind;
	assign frame_opcode  = res_q.opcode;
	assign payload_byte  = res_q.data;
	assign last_of_frame = res_q.last;

endmodule

// ===== test/websocket_frame_deframer_tb.sv =====
// Self-checking testbench for websocket_frame_deframer: directed and random frames
// are checked against a scoreboard that parses the same byte stream.
// Depends on wsfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
	import wsfd_pkg::*;

	// Length encodings a frame header can use.
	localparam int ENC_SHORT = 0;
	localparam int ENC_16 = 1;
	localparam int ENC_64 = 2;

	// Cycles to let a byte still inside the pipeline settle.
	localparam int SETTLE_CYCLES = 6;
	// Around 1600 bytes, plus drains.
	localparam int CYCLE_LIMIT = 400000;

	// Shadow parser: follows the accepted byte stream and queues the words
	// that the block must produce.
	class ws_frame_scoreboard;
		logic [CAP_W-1:0] max_len;
		logic [PH_W-1:0] phase;
		logic [3:0] opcode;
		logic masked;
		logic [LEN_W-1:0] len_left;
		logic [3:0] hdr_left;
		logic [31:0] key;
		logic [20:0] pay_idx;
		wsfd_result_t expected_words[$];
		int errors;

		function new();
			max_len = CAP_RESET;
			phase = PH_HDR0;
			opcode = '0;
			masked = 1'b0;
			len_left = '0;
			hdr_left = '0;
			key = '0;
			pay_idx = '0;
			errors = 0;
		endfunction

		// The header is complete: either the frame is empty or payload follows.
		function wsfd_result_t start_body();
			wsfd_result_t r;
			r = '0;
			if (len_left == 0) begin
				r.valid = 1'b1;
				r.kind = KIND_EMPTY;
				r.opcode = opcode;
				r.last = 1'b1;
				phase = PH_HDR0;
			end else begin
				pay_idx = '0;
				phase = PH_PAYLOAD;
			end
			return r;
		endfunction

		// The declared length is known: check it against the cap before any key byte.
		function wsfd_result_t length_known();
			wsfd_result_t r;
			r = '0;
			if (len_left > max_len) begin
				r.valid = 1'b1;
				r.kind = KIND_OVERSIZE;
				r.opcode = OPC_CLOSE;
				r.last = 1'b1;
				phase = PH_HALT;
			end else if (masked) begin
				hdr_left = KEY_BYTES;
				key = '0;
				phase = PH_KEY;
			end else begin
				r = start_body();
			end
			return r;
		endfunction

		function void note_rx_byte(logic [7:0] b);
			wsfd_result_t r;
			logic [1:0] sel;
			logic [7:0] k;
			r = '0;
			case (phase)
				PH_HDR0: begin
					opcode = b[3:0];
					phase = PH_HDR1;
				end
				PH_HDR1: begin
					masked = b[7];
					len_left = '0;
					if (b[6:0] == LEN_CODE16) begin
						hdr_left = EXT16_BYTES;
						phase = PH_EXTLEN;
					end else if (b[6:0] == LEN_CODE64) begin
						hdr_left = EXT64_BYTES;
						phase = PH_EXTLEN;
					end else begin
						len_left = LEN_W'(b[6:0]);
						r = length_known();
					end
				end
				PH_EXTLEN: begin
					len_left = {len_left[LEN_W-9:0], b};
					hdr_left = hdr_left - 4'd1;
					if (hdr_left == 0)
						r = length_known();
				end
				PH_KEY: begin
					key = {key[23:0], b};
					hdr_left = hdr_left - 4'd1;
					if (hdr_left == 0)
						r = start_body();
				end
				PH_PAYLOAD: begin
					// The first key byte received sits in the top bits of the key.
					sel = 2'd3 - pay_idx[1:0];
					k = masked ? key[8*sel +: 8] : 8'h00;
					pay_idx = pay_idx + 21'd1;
					len_left = len_left - 1;
					r.valid = 1'b1;
					r.kind = KIND_PAYLOAD;
					r.opcode = opcode;
					r.data = b ^ k;
					r.last = (len_left == 0);
					if (r.last)
						phase = PH_HDR0;
				end
				default: phase = PH_HALT;
			endcase
			if (r.valid)
				expected_words = {expected_words, r};
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", msg);
		endtask

		task check_result_word(logic [1:0] kind, logic [3:0] opc, logic [7:0] data, logic last);
			wsfd_result_t e;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word kind=%0d opcode=%0h data=%02h last=%0b",
					kind, opc, data, last));
				return;
			end
			e = expected_words.pop_front();
			if (kind !== e.kind || opc !== e.opcode || data !== e.data || last !== e.last)
				report_mismatch($sformatf(
					"got kind=%0d opcode=%0h data=%02h last=%0b, want %0d %0h %02h %0b",
					kind, opc, data, last, e.kind, e.opcode, e.data, e.last));
		endtask

		task check_drained();
			if (expected_words.size() != 0)
				report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] rx_byte;
	logic cfg_wr_en;
	logic [CAP_W-1:0] cfg_wr_data;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] result_kind;
	logic [3:0] frame_opcode;
	logic [7:0] payload_byte;
	logic last_of_frame;

	ws_frame_scoreboard sb;
	logic [CAP_W-1:0] cur_cap;
	int src_gap_pct;
	int sink_stall_pct;
	int sent_bytes;
	int cycles = 0;

	// Hand-made frames: extreme payload bytes, empty frames, non-minimal lengths.
	logic [7:0] directed_bytes[] = '{
		8'h81, 8'h02, 8'h00, 8'hFF,
		8'h0F, 8'h80, 8'hFF, 8'h00, 8'hAA, 8'h55,
		8'hF2, 8'h00,
		8'h09, {1'b1, LEN_CODE16}, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF,
		8'h0A, {1'b0, LEN_CODE64}, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
		8'h5A
	};

	websocket_frame_deframer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.frame_opcode(frame_opcode),
		.payload_byte(payload_byte),
		.last_of_frame(last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver back-pressure, changed on the falling edge.
	always @(negedge clk) begin
		out_stall = (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
	end

	// Both channels are sampled at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result_word(result_kind, frame_opcode, payload_byte, last_of_frame);
			if (in_valid && !in_stall)
				sb.note_rx_byte(rx_byte);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** websocket_frame_deframer: FAILED **");
			$finish;
		end
	end

	// Offer one byte and hold it until the block takes the word.
	task automatic send_byte(input logic [7:0] b);
		while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		sent_bytes++;
	endtask

	task automatic send_frame(input logic [3:0] opc, input logic masked, input int unsigned len,
			input int enc);
		logic [7:0] frame[$];
		logic [63:0] wide;
		logic [3:0] top;
		int i;
		wide = 64'(len);
		top = 4'($urandom_range(15));
		frame = {frame, {top, opc}};
		if (enc == ENC_SHORT) begin
			frame = {frame, {masked, wide[6:0]}};
		end else if (enc == ENC_16) begin
			frame = {frame, {masked, LEN_CODE16}};
			frame = {frame, wide[15:8]};
			frame = {frame, wide[7:0]};
		end else begin
			frame = {frame, {masked, LEN_CODE64}};
			for (i = 7; i >= 0; i--)
				frame = {frame, wide[8*i +: 8]};
		end
		if (masked)
			for (i = 0; i < 4; i++)
				frame = {frame, 8'($urandom_range(255))};
		for (i = 0; i < len; i++)
			frame = {frame, 8'($urandom_range(255))};
		foreach (frame[j])
			send_byte(frame[j]);
	endtask

	// Mostly short frames, some medium, now and then a long one (right at the cap when the cap is small).
	task automatic send_random_frame();
		int unsigned len;
		int unsigned pick;
		int enc;
		pick = $urandom_range(99);
		if (pick < 60)
			len = $urandom_range(20);
		else if (pick < 88)
			len = $urandom_range(125, 21);
		else if (pick < 98)
			len = $urandom_range(400, 126);
		else
			len = (cur_cap <= 600) ? 32'(cur_cap) : $urandom_range(600, 401);
		if (len > cur_cap)
			len = 32'(cur_cap);
		pick = $urandom_range(99);
		if (len <= 125)
			enc = (pick < 60) ? ENC_SHORT : (pick < 85) ? ENC_16 : ENC_64;
		else
			enc = (pick < 80) ? ENC_16 : ENC_64;
		send_frame(4'($urandom_range(15)), $urandom_range(99) < 75, len, enc);
	endtask

	// Wait until every expected word has come out and the pipeline is empty.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (sb.expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_cap(input logic [CAP_W-1:0] v);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cur_cap = v;
		sb.max_len = v;
	endtask

	initial begin
		int gap_pcts[4];
		int stall_pcts[4];
		logic [CAP_W-1:0] caps[4];
		int ph;
		int start;
		int i;

		// Known values on every input from time zero.
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		src_gap_pct = 0;
		sink_stall_pct = 0;
		sent_bytes = 0;

		gap_pcts = '{0, 50, 0, 9};
		stall_pcts = '{0, 0, 50, 9};
		caps = '{21'h1FFFFF, CAP_RESET, CAP_W'($urandom_range(300, 30)),
			CAP_W'($urandom_range(21'h1FFFFF, 1))};
		sb = new();
		cur_cap = CAP_RESET;

		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed frames at the reset cap.
		foreach (directed_bytes[j])
			send_byte(directed_bytes[j]);
		send_frame(4'h0, 1'b1, 125, ENC_SHORT);
		wait_idle();

		// Random frames under each idling pattern and cap setting.
		for (ph = 0; ph < 4; ph++) begin
			src_gap_pct = gap_pcts[ph];
			sink_stall_pct = stall_pcts[ph];
			write_cap(caps[ph]);
			start = sent_bytes;
			while (sent_bytes - start < 280)
				send_random_frame();
			wait_idle();
		end

		// A zero cap still lets empty frames through in every encoding.
		src_gap_pct = 9;
		sink_stall_pct = 9;
		write_cap('0);
		send_frame(4'($urandom_range(15)), 1'b1, 0, ENC_SHORT);
		send_frame(4'($urandom_range(15)), 1'b0, 0, ENC_16);
		send_frame(4'($urandom_range(15)), 1'b1, 0, ENC_64);

		// Cap raised while a 16-bit length is half read; the new cap must apply.
		send_byte(8'h01);
		send_byte({1'b1, LEN_CODE16});
		send_byte(8'h00);
		wait_idle();
		write_cap(21'd50);
		send_byte(8'd40);
		for (i = 0; i < 44; i++)
			send_byte(8'($urandom_range(255)));
		wait_idle();

		// Oversize close on a 64-bit length that a truncated compare would miss,
		// then bytes that the halted block must drop.
		write_cap(21'd100);
		send_byte(8'h82);
		send_byte({1'b1, LEN_CODE64});
		send_byte(8'h80);
		for (i = 0; i < 7; i++)
			send_byte(8'h00);
		for (i = 0; i < 12; i++)
			send_byte(8'($urandom_range(255)));
		wait_idle();
		repeat (8) @(negedge clk);

		sb.check_drained();
		if (sb.errors == 0)
			$display("** websocket_frame_deframer: PASSED **");
		else
			$display("** websocket_frame_deframer: FAILED **");
		$finish;
	end

endmodule
